// ----- sv/pcfs_pkg.sv -----
package pcfs_pkg;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_t;

  localparam logic [4:0] OFF_CH1_LAST = 5'h03;
  localparam logic [4:0] OFF_CH2_LAST = 5'h07;
  localparam logic [4:0] OFF_ENABLE   = 5'h15;
  localparam logic [4:0] OFF_FRAME    = 5'h17;

  localparam logic [1:0] SEL_CONTROL = 2'd0;
  localparam logic [1:0] SEL_SWEEP   = 2'd1;
  localparam logic [1:0] SEL_LOW     = 2'd2;
  localparam logic [1:0] SEL_HIGH    = 2'd3;

  localparam logic [3:0]  DECAY_MAX  = 4'd15;
  localparam logic [10:0] MIN_PERIOD = 11'd8;

  localparam logic [7:0] LEN_TABLE [32] = '{
    8'd10,  8'd254, 8'd20, 8'd2,  8'd40, 8'd4,  8'd80, 8'd6,
    8'd160, 8'd8,   8'd60, 8'd10, 8'd14, 8'd12, 8'd26, 8'd14,
    8'd12,  8'd16,  8'd24, 8'd18, 8'd48, 8'd20, 8'd96, 8'd22,
    8'd192, 8'd24,  8'd72, 8'd26, 8'd16, 8'd28, 8'd32, 8'd30
  };

  typedef struct packed {
    logic       wr;
    logic [1:0] sel;
    logic       en_wr;
    logic       en_bit;
    logic       quarter;
    logic       half;
    logic [7:0] data;
  } chan_ctrl_t;

  typedef struct packed {
    logic        length_nz;
    logic [3:0]  volume;
    logic [10:0] period;
    logic [1:0]  duty;
  } chan_status_t;

  typedef struct packed {
    logic frame_wr;
    logic status_rd;
    logic tick;
  } seq_ctrl_t;

  typedef struct packed {
    logic quarter;
    logic half;
    logic irq;
    logic irq_next;
  } seq_status_t;

  // Sweep target before the mute check; the top bit flags an overflow.
  function automatic logic [11:0] sweep_sum(input logic [10:0] period,
                                            input logic [7:0]  fields,
                                            input logic        borrow);
    logic [11:0] change;
    change = {1'b0, period >> fields[2:0]};
    if (fields[3]) begin
      sweep_sum = {1'b0, period} - change - {11'd0, borrow};
    end else begin
      sweep_sum = {1'b0, period} + change;
    end
  endfunction

  function automatic logic sweep_mutes(input logic [10:0] period,
                                       input logic [7:0]  fields,
                                       input logic        borrow);
    logic [11:0] sum;
    sum = sweep_sum(period, fields, borrow);
    sweep_mutes = (period < MIN_PERIOD) || (!fields[3] && sum[11]);
  endfunction

endpackage

// ----- sv/pcfs_if.sv -----
interface pcfs_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [4:0] reg_offset;
  logic [7:0] data;

  modport source (output valid, output cmd, output reg_offset, output data, input ready);
  modport sink (input valid, input cmd, input reg_offset, input data, output ready);
endinterface

interface pcfs_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic        frame_irq;
  logic [3:0]  pulse1_volume;
  logic [3:0]  pulse2_volume;
  logic [10:0] pulse1_period;
  logic [10:0] pulse2_period;
  logic [1:0]  pulse1_duty;
  logic [1:0]  pulse2_duty;

  modport source (output valid, output read_data, output frame_irq,
                  output pulse1_volume, output pulse2_volume,
                  output pulse1_period, output pulse2_period,
                  output pulse1_duty, output pulse2_duty, input ready);
  modport sink (input valid, input read_data, input frame_irq,
                input pulse1_volume, input pulse2_volume,
                input pulse1_period, input pulse2_period,
                input pulse1_duty, input pulse2_duty, output ready);
endinterface

// ----- sv/pcfs_channel.sv -----
module pcfs_channel (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic                  borrow,
  input  pcfs_pkg::chan_ctrl_t  ctrl,
  output pcfs_pkg::chan_status_t status
);

  logic [10:0] timer_period,    timer_period_next;
  logic [7:0]  length_count,    length_count_next;
  logic        channel_enable,  channel_enable_next;
  logic [1:0]  duty_select,     duty_select_next;
  logic        halt_loop,       halt_loop_next;
  logic        fixed_volume,    fixed_volume_next;
  logic [3:0]  volume_period,   volume_period_next;
  logic        env_start,       env_start_next;
  logic [4:0]  env_divider,     env_divider_next;
  logic [3:0]  env_decay,       env_decay_next;
  logic [7:0]  sweep_fields,    sweep_fields_next;
  logic [3:0]  sweep_divider,   sweep_divider_next;
  logic        sweep_reload,    sweep_reload_next;
  logic [11:0] target;
  logic        mute_now;

  assign target   = pcfs_pkg::sweep_sum(timer_period, sweep_fields, borrow);
  assign mute_now = pcfs_pkg::sweep_mutes(timer_period, sweep_fields, borrow);

  always_comb begin
    timer_period_next    = timer_period;
    length_count_next    = length_count;
    channel_enable_next  = channel_enable;
    duty_select_next     = duty_select;
    halt_loop_next       = halt_loop;
    fixed_volume_next    = fixed_volume;
    volume_period_next   = volume_period;
    env_start_next       = env_start;
    env_divider_next     = env_divider;
    env_decay_next       = env_decay;
    sweep_fields_next    = sweep_fields;
    sweep_divider_next   = sweep_divider;
    sweep_reload_next    = sweep_reload;

    if (ctrl.wr) begin
      unique case (ctrl.sel)
        pcfs_pkg::SEL_CONTROL: begin
          duty_select_next     = ctrl.data[7:6];
          halt_loop_next       = ctrl.data[5];
          fixed_volume_next    = ctrl.data[4];
          volume_period_next   = ctrl.data[3:0];
        end
        pcfs_pkg::SEL_SWEEP: begin
          sweep_fields_next = ctrl.data;
          sweep_reload_next = 1'b1;
        end
        pcfs_pkg::SEL_LOW: begin
          timer_period_next = {timer_period[10:8], ctrl.data};
        end
        pcfs_pkg::SEL_HIGH: begin
          timer_period_next = {ctrl.data[2:0], timer_period[7:0]};
          if (channel_enable) begin
            length_count_next = pcfs_pkg::LEN_TABLE[ctrl.data[7:3]];
          end
          env_start_next = 1'b1;
        end
        default: begin
        end
      endcase
    end

    if (ctrl.en_wr) begin
      channel_enable_next = ctrl.en_bit;
      if (!ctrl.en_bit) begin
        length_count_next = 8'd0;
      end
    end

    if (ctrl.quarter) begin
      if (env_start) begin
        env_start_next   = 1'b0;
        env_decay_next   = pcfs_pkg::DECAY_MAX;
        env_divider_next = {1'b0, volume_period};
      end else if (env_divider == 5'd0) begin
        env_divider_next = {1'b0, volume_period};
        if (env_decay != 4'd0) begin
          env_decay_next = env_decay - 4'd1;
        end else if (halt_loop) begin
          env_decay_next = pcfs_pkg::DECAY_MAX;
        end
      end else begin
        env_divider_next = env_divider - 5'd1;
      end
    end

    if (ctrl.half) begin
      if (!halt_loop && length_count != 8'd0) begin
        length_count_next = length_count - 8'd1;
      end
      if (sweep_divider == 4'd0 && sweep_fields[7] && sweep_fields[2:0] != 3'd0 &&
          !mute_now) begin
        timer_period_next = target[10:0];
      end
      if (sweep_divider == 4'd0 || sweep_reload) begin
        sweep_divider_next = {1'b0, sweep_fields[6:4]};
        sweep_reload_next  = 1'b0;
      end else begin
        sweep_divider_next = sweep_divider - 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timer_period    <= '0;
      length_count    <= '0;
      channel_enable  <= 1'b0;
      duty_select     <= '0;
      halt_loop       <= 1'b0;
      fixed_volume    <= 1'b0;
      volume_period   <= '0;
      env_start       <= 1'b0;
      env_divider     <= '0;
      env_decay       <= '0;
      sweep_fields    <= '0;
      sweep_divider   <= '0;
      sweep_reload    <= 1'b0;
    end else if (step) begin
      timer_period    <= timer_period_next;
      length_count    <= length_count_next;
      channel_enable  <= channel_enable_next;
      duty_select     <= duty_select_next;
      halt_loop       <= halt_loop_next;
      fixed_volume    <= fixed_volume_next;
      volume_period   <= volume_period_next;
      env_start       <= env_start_next;
      env_divider     <= env_divider_next;
      env_decay       <= env_decay_next;
      sweep_fields    <= sweep_fields_next;
      sweep_divider   <= sweep_divider_next;
      sweep_reload    <= sweep_reload_next;
    end
  end

  always_comb begin
    status.length_nz = (length_count != 8'd0);
    status.period    = timer_period_next;
    status.duty      = duty_select_next;
    if (length_count_next == 8'd0 ||
        pcfs_pkg::sweep_mutes(timer_period_next, sweep_fields_next, borrow)) begin
      status.volume = 4'd0;
    end else if (fixed_volume_next) begin
      status.volume = volume_period_next;
    end else begin
      status.volume = env_decay_next;
    end
  end

endmodule

// ----- sv/pcfs_sequencer.sv -----
module pcfs_sequencer (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  pcfs_pkg::seq_ctrl_t   ctrl,
  input  logic [7:0]            data,
  output pcfs_pkg::seq_status_t status
);

  logic       seq_mode,    seq_mode_next;
  logic       irq_inhibit, irq_inhibit_next;
  logic [2:0] seq_step,    seq_step_next;
  logic       irq_pending, irq_pending_next;
  logic [2:0] last;
  logic [2:0] cur;

  assign last = seq_mode ? 3'd4 : 3'd3;
  assign cur  = (seq_step > last) ? 3'd0 : seq_step;

  always_comb begin
    seq_mode_next    = seq_mode;
    irq_inhibit_next = irq_inhibit;
    seq_step_next    = seq_step;
    irq_pending_next = irq_pending;
    status.quarter   = 1'b0;
    status.half      = 1'b0;

    if (ctrl.frame_wr) begin
      seq_mode_next    = data[7];
      irq_inhibit_next = data[6];
      if (data[6]) begin
        irq_pending_next = 1'b0;
      end
      seq_step_next  = 3'd0;
      status.quarter = data[7];
      status.half    = data[7];
    end

    if (ctrl.status_rd) begin
      irq_pending_next = 1'b0;
    end

    if (ctrl.tick) begin
      if (!seq_mode) begin
        status.quarter = 1'b1;
        status.half    = (cur == 3'd1) || (cur == 3'd3);
        if (cur == 3'd3 && !irq_inhibit) begin
          irq_pending_next = 1'b1;
        end
      end else begin
        status.quarter = (cur != 3'd3);
        status.half    = (cur == 3'd1) || (cur == 3'd4);
      end
      seq_step_next = (cur >= last) ? 3'd0 : cur + 3'd1;
    end

    status.irq      = irq_pending;
    status.irq_next = irq_pending_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_mode    <= 1'b0;
      irq_inhibit <= 1'b0;
      seq_step    <= '0;
      irq_pending <= 1'b0;
    end else if (step) begin
      seq_mode    <= seq_mode_next;
      irq_inhibit <= irq_inhibit_next;
      seq_step    <= seq_step_next;
      irq_pending <= irq_pending_next;
    end
  end

endmodule

// ----- sv/pulse_channel_frame_sequencer_core.sv -----
// Two pulse-channel control units and a frame sequencer behind a pair of
// valid/ready channels. Each request beat carries a command (register write,
// status read or quarter-frame tick), a register offset and a data byte.
// Each request gives exactly one response beat with the status byte, the
// frame IRQ level and both channels' volume, period and duty.
// A request is captured in an input register at the edge that accepts it and
// is applied to the channel and sequencer state when it leaves that register,
// at the edge where the response is also registered. One request is taken
// every cycle while the receiver does not stall, set by the single state
// update per cycle in the channel and sequencer registers.
// When the receiver stalls, the response register and the input register hold
// their beats and ready falls only when both are full.
// Reset clears all channel and sequencer state and empties both registers.
module pulse_channel_frame_sequencer_core (
  input  logic       clk,
  input  logic       rst,
  pcfs_req_if.sink   req,
  pcfs_rsp_if.source rsp
);

  logic       item_valid;
  logic [1:0] item_cmd;
  logic [4:0] item_offset;
  logic [7:0] item_data;
  logic       advance;

  logic        rsp_valid;
  logic [7:0]  read_data;
  logic        frame_irq;
  logic [3:0]  pulse1_volume;
  logic [3:0]  pulse2_volume;
  logic [10:0] pulse1_period;
  logic [10:0] pulse2_period;
  logic [1:0]  pulse1_duty;
  logic [1:0]  pulse2_duty;

  pcfs_pkg::chan_ctrl_t   ch1_ctrl, ch2_ctrl;
  pcfs_pkg::chan_status_t ch1_status, ch2_status;
  pcfs_pkg::seq_ctrl_t    seq_ctrl;
  pcfs_pkg::seq_status_t  seq_status;
  logic                   is_write;
  logic                   is_read;
  logic                   enable_wr;

  assign advance   = item_valid && (!rsp_valid || rsp.ready);
  assign req.ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (req.ready) begin
      item_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      item_cmd    <= req.cmd;
      item_offset <= req.reg_offset;
      item_data   <= req.data;
    end
  end

  always_comb begin
    is_write           = 1'b0;
    is_read            = 1'b0;
    seq_ctrl.tick      = 1'b0;
    unique case (pcfs_pkg::cmd_t'(item_cmd))
      pcfs_pkg::CMD_WRITE: is_write = 1'b1;
      pcfs_pkg::CMD_READ:  is_read = 1'b1;
      pcfs_pkg::CMD_TICK:  seq_ctrl.tick = 1'b1;
      default: begin
      end
    endcase
    seq_ctrl.status_rd = is_read;
    seq_ctrl.frame_wr  = is_write && (item_offset == pcfs_pkg::OFF_FRAME);
    enable_wr          = is_write && (item_offset == pcfs_pkg::OFF_ENABLE);
  end

  always_comb begin
    ch1_ctrl.wr      = is_write && (item_offset <= pcfs_pkg::OFF_CH1_LAST);
    ch1_ctrl.sel     = item_offset[1:0];
    ch1_ctrl.en_wr   = enable_wr;
    ch1_ctrl.en_bit  = item_data[0];
    ch1_ctrl.quarter = seq_status.quarter;
    ch1_ctrl.half    = seq_status.half;
    ch1_ctrl.data    = item_data;

    ch2_ctrl.wr      = is_write && (item_offset > pcfs_pkg::OFF_CH1_LAST) &&
                       (item_offset <= pcfs_pkg::OFF_CH2_LAST);
    ch2_ctrl.sel     = item_offset[1:0];
    ch2_ctrl.en_wr   = enable_wr;
    ch2_ctrl.en_bit  = item_data[1];
    ch2_ctrl.quarter = seq_status.quarter;
    ch2_ctrl.half    = seq_status.half;
    ch2_ctrl.data    = item_data;
  end

  pcfs_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .ctrl   (seq_ctrl),
    .data   (item_data),
    .status (seq_status)
  );

  pcfs_channel u_ch1 (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .borrow (1'b1),
    .ctrl   (ch1_ctrl),
    .status (ch1_status)
  );

  pcfs_channel u_ch2 (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .borrow (1'b0),
    .ctrl   (ch2_ctrl),
    .status (ch2_status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      read_data     <= is_read ? {1'b0, seq_status.irq, 4'd0,
                                  ch2_status.length_nz, ch1_status.length_nz} : 8'd0;
      frame_irq     <= seq_status.irq_next;
      pulse1_volume <= ch1_status.volume;
      pulse2_volume <= ch2_status.volume;
      pulse1_period <= ch1_status.period;
      pulse2_period <= ch2_status.period;
      pulse1_duty   <= ch1_status.duty;
      pulse2_duty   <= ch2_status.duty;
    end
  end

  assign rsp.valid         = rsp_valid;
  assign rsp.read_data     = read_data;
  assign rsp.frame_irq     = frame_irq;
  assign rsp.pulse1_volume = pulse1_volume;
  assign rsp.pulse2_volume = pulse2_volume;
  assign rsp.pulse1_period = pulse1_period;
  assign rsp.pulse2_period = pulse2_period;
  assign rsp.pulse1_duty   = pulse1_duty;
  assign rsp.pulse2_duty   = pulse2_duty;

endmodule

// ----- test/pulse_channel_frame_sequencer_core_tb.sv -----
module pulse_channel_frame_sequencer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_UNKNOWN    = 2'd3;
  localparam logic [4:0] OFF_UNUSED_MID = 5'h10;
  localparam logic [4:0] OFF_UNUSED_TOP = 5'h1F;
  localparam int         PERIOD_MAX     = 'h7FF;
  localparam int         IDLE_LIMIT     = 5000;
  localparam int         HOLD_CYCLES    = 300;
  localparam int         MAX_PRINTS     = 50;

  typedef struct packed {
    logic [1:0] cmd;
    logic [4:0] off;
    logic [7:0] data;
  } bus_op_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        frame_irq;
    logic [3:0]  vol1;
    logic [3:0]  vol2;
    logic [10:0] per1;
    logic [10:0] per2;
    logic [1:0]  duty1;
    logic [1:0]  duty2;
  } apu_status_t;

  typedef struct {
    logic [10:0] period;
    logic [7:0]  length;
    logic        enable;
    logic [1:0]  duty;
    logic        halt;
    logic        const_vol;
    logic [3:0]  vol;
    logic        env_start;
    logic [4:0]  env_div;
    logic [3:0]  decay;
    logic [7:0]  sweep;
    logic [3:0]  sweep_div;
    logic        sweep_reload;
  } pulse_state_t;

  logic clk;
  logic rst;

  pcfs_req_if req_ch ();
  pcfs_rsp_if rsp_ch ();

  pulse_channel_frame_sequencer_core dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  pulse_state_t pulse [2];
  logic         seq5;
  logic         inhibit;
  logic [2:0]   step;
  logic         irq;

  bus_op_t     bus_ops [$];
  apu_status_t status_expected [$];
  bus_op_t     offered;
  apu_status_t want;
  int          tx_idle_pct;
  int          rx_stall_pct;
  int          hold_left;
  int          idle_cycles;
  int          errors;

  always #6 clk = ~clk;

  function automatic int sweep_target(int ch);
    int p;
    int change;
    p = int'(pulse[ch].period);
    change = p >> pulse[ch].sweep[2:0];
    if (pulse[ch].sweep[3]) begin
      return p - change - ((ch == 0) ? 1 : 0);
    end
    return p + change;
  endfunction

  function automatic logic sweep_muted(int ch);
    return (pulse[ch].period < pcfs_pkg::MIN_PERIOD) || (sweep_target(ch) > PERIOD_MAX);
  endfunction

  function automatic void clock_envelopes();
    for (int ch = 0; ch < 2; ch++) begin
      if (pulse[ch].env_start) begin
        pulse[ch].env_start = 1'b0;
        pulse[ch].decay = pcfs_pkg::DECAY_MAX;
        pulse[ch].env_div = {1'b0, pulse[ch].vol};
      end else if (pulse[ch].env_div == 5'd0) begin
        pulse[ch].env_div = {1'b0, pulse[ch].vol};
        if (pulse[ch].decay > 4'd0) begin
          pulse[ch].decay = pulse[ch].decay - 4'd1;
        end else if (pulse[ch].halt) begin
          pulse[ch].decay = pcfs_pkg::DECAY_MAX;
        end
      end else begin
        pulse[ch].env_div = pulse[ch].env_div - 5'd1;
      end
    end
  endfunction

  function automatic void clock_half_frame();
    int tgt;
    for (int ch = 0; ch < 2; ch++) begin
      if (!pulse[ch].halt && pulse[ch].length > 8'd0) begin
        pulse[ch].length = pulse[ch].length - 8'd1;
      end
      if (pulse[ch].sweep_div == 4'd0 && pulse[ch].sweep[7] && pulse[ch].sweep[2:0] != 3'd0 &&
          !sweep_muted(ch)) begin
        tgt = sweep_target(ch);
        pulse[ch].period = tgt[10:0];
      end
      if (pulse[ch].sweep_div == 4'd0 || pulse[ch].sweep_reload) begin
        pulse[ch].sweep_div = {1'b0, pulse[ch].sweep[6:4]};
        pulse[ch].sweep_reload = 1'b0;
      end else begin
        pulse[ch].sweep_div = pulse[ch].sweep_div - 4'd1;
      end
    end
  endfunction

  function automatic void write_register(logic [4:0] off, logic [7:0] d);
    int ch;
    if (off <= pcfs_pkg::OFF_CH2_LAST) begin
      ch = int'(off[2]);
      case (off[1:0])
        pcfs_pkg::SEL_CONTROL: begin
          pulse[ch].duty = d[7:6];
          pulse[ch].halt = d[5];
          pulse[ch].const_vol = d[4];
          pulse[ch].vol = d[3:0];
        end
        pcfs_pkg::SEL_SWEEP: begin
          pulse[ch].sweep = d;
          pulse[ch].sweep_reload = 1'b1;
        end
        pcfs_pkg::SEL_LOW: begin
          pulse[ch].period[7:0] = d;
        end
        default: begin
          pulse[ch].period[10:8] = d[2:0];
          if (pulse[ch].enable) begin
            pulse[ch].length = pcfs_pkg::LEN_TABLE[d[7:3]];
          end
          pulse[ch].env_start = 1'b1;
        end
      endcase
    end else if (off == pcfs_pkg::OFF_ENABLE) begin
      for (int c = 0; c < 2; c++) begin
        pulse[c].enable = d[c];
        if (!d[c]) begin
          pulse[c].length = 8'd0;
        end
      end
    end else if (off == pcfs_pkg::OFF_FRAME) begin
      seq5 = d[7];
      inhibit = d[6];
      if (inhibit) begin
        irq = 1'b0;
      end
      step = 3'd0;
      if (seq5) begin
        clock_envelopes();
        clock_half_frame();
      end
    end
  endfunction

  function automatic void advance_sequencer();
    logic [2:0] last;
    logic [2:0] s;
    logic       quarter;
    logic       half;
    last = seq5 ? 3'd4 : 3'd3;
    s = (step > last) ? 3'd0 : step;
    if (!seq5) begin
      quarter = 1'b1;
      half = (s == 3'd1) || (s == 3'd3);
      if (s == 3'd3 && !inhibit) begin
        irq = 1'b1;
      end
    end else begin
      quarter = (s != 3'd3);
      half = (s == 3'd1) || (s == 3'd4);
    end
    if (quarter) begin
      clock_envelopes();
    end
    if (half) begin
      clock_half_frame();
    end
    step = (s >= last) ? 3'd0 : s + 3'd1;
  endfunction

  function automatic logic [3:0] volume_of(int ch);
    if (pulse[ch].length == 8'd0 || sweep_muted(ch)) begin
      return 4'd0;
    end
    return pulse[ch].const_vol ? pulse[ch].vol : pulse[ch].decay;
  endfunction

  function automatic apu_status_t apu_apply(bus_op_t op);
    apu_status_t st;
    st.read_data = 8'd0;
    case (op.cmd)
      pcfs_pkg::CMD_WRITE: begin
        write_register(op.off, op.data);
      end
      pcfs_pkg::CMD_READ: begin
        st.read_data = {1'b0, irq, 4'd0, pulse[1].length != 8'd0, pulse[0].length != 8'd0};
        irq = 1'b0;
      end
      pcfs_pkg::CMD_TICK: begin
        advance_sequencer();
      end
      default: begin
      end
    endcase
    st.frame_irq = irq;
    st.vol1 = volume_of(0);
    st.vol2 = volume_of(1);
    st.per1 = pulse[0].period;
    st.per2 = pulse[1].period;
    st.duty1 = pulse[0].duty;
    st.duty2 = pulse[1].duty;
    return st;
  endfunction

  function automatic void apu_clear();
    for (int ch = 0; ch < 2; ch++) begin
      pulse[ch] = '{default: '0};
    end
    seq5 = 1'b0;
    inhibit = 1'b0;
    step = 3'd0;
    irq = 1'b0;
  endfunction

  function automatic logic [4:0] chan_reg(int ch, logic [1:0] sel);
    return {2'b00, ch[0], sel};
  endfunction

  task automatic push_op(logic [1:0] cmd, logic [4:0] off, logic [7:0] d);
    bus_ops.push_back('{cmd: cmd, off: off, data: d});
  endtask

  task automatic push_random_op();
    int         r;
    logic [4:0] off;
    logic [7:0] d;
    r = $urandom_range(99);
    off = 5'($urandom_range(31));
    d = 8'($urandom_range(255));
    if (r < 45) begin
      push_op(pcfs_pkg::CMD_WRITE, 5'($urandom_range(pcfs_pkg::OFF_CH2_LAST)), d);
    end else if (r < 52) begin
      if ($urandom_range(3) != 0) begin
        d[1:0] = 2'b11;
      end
      push_op(pcfs_pkg::CMD_WRITE, pcfs_pkg::OFF_ENABLE, d);
    end else if (r < 55) begin
      push_op(pcfs_pkg::CMD_WRITE, pcfs_pkg::OFF_FRAME, d);
    end else if (r < 58) begin
      off = 5'($urandom_range(8, 31));
      if (off == pcfs_pkg::OFF_ENABLE || off == pcfs_pkg::OFF_FRAME) begin
        off = off + 5'd1;
      end
      push_op(pcfs_pkg::CMD_WRITE, off, d);
    end else if (r < 70) begin
      push_op(pcfs_pkg::CMD_READ, off, d);
    end else if (r < 96) begin
      push_op(pcfs_pkg::CMD_TICK, off, d);
    end else begin
      push_op(CMD_UNKNOWN, off, d);
    end
  endtask

  // A full channel set-up in register order, followed by a run of frame ticks with occasional status reads.
  task automatic push_note();
    int ch;
    int ticks;
    ch = $urandom_range(1);
    ticks = $urandom_range(4, 12);
    push_op(pcfs_pkg::CMD_WRITE, chan_reg(ch, pcfs_pkg::SEL_CONTROL), 8'($urandom_range(255)));
    push_op(pcfs_pkg::CMD_WRITE, chan_reg(ch, pcfs_pkg::SEL_SWEEP), 8'($urandom_range(255)));
    push_op(pcfs_pkg::CMD_WRITE, chan_reg(ch, pcfs_pkg::SEL_LOW), 8'($urandom_range(255)));
    push_op(pcfs_pkg::CMD_WRITE, chan_reg(ch, pcfs_pkg::SEL_HIGH), 8'($urandom_range(255)));
    repeat (ticks) begin
      if ($urandom_range(5) == 0) begin
        push_op(pcfs_pkg::CMD_READ, 5'($urandom_range(31)), 8'($urandom_range(255)));
      end else begin
        push_op(pcfs_pkg::CMD_TICK, 5'($urandom_range(31)), 8'($urandom_range(255)));
      end
    end
  endtask

  task automatic push_random_phase(int n);
    repeat (n) begin
      if ($urandom_range(9) == 0) begin
        push_note();
      end else begin
        push_random_op();
      end
    end
  endtask

  task automatic wait_sent();
    while (bus_ops.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic report_mismatch(string field, int got, int exp_val);
    errors++;
    if (errors <= MAX_PRINTS) begin
      $display("mismatch on %s: got %0d, want %0d", field, got, exp_val);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        status_expected.push_back(apu_apply(offered));
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (bus_ops.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          offered = bus_ops.pop_front();
          req_ch.cmd <= offered.cmd;
          req_ch.reg_offset <= offered.off;
          req_ch.data <= offered.data;
          req_ch.valid <= 1'b1;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (status_expected.size() == 0) begin
          report_mismatch("unexpected beat", 1, 0);
        end else begin
          want = status_expected.pop_front();
          if (rsp_ch.read_data !== want.read_data)
            report_mismatch("read_data", rsp_ch.read_data, want.read_data);
          if (rsp_ch.frame_irq !== want.frame_irq)
            report_mismatch("frame_irq", rsp_ch.frame_irq, want.frame_irq);
          if (rsp_ch.pulse1_volume !== want.vol1)
            report_mismatch("pulse1_volume", rsp_ch.pulse1_volume, want.vol1);
          if (rsp_ch.pulse2_volume !== want.vol2)
            report_mismatch("pulse2_volume", rsp_ch.pulse2_volume, want.vol2);
          if (rsp_ch.pulse1_period !== want.per1)
            report_mismatch("pulse1_period", rsp_ch.pulse1_period, want.per1);
          if (rsp_ch.pulse2_period !== want.per2)
            report_mismatch("pulse2_period", rsp_ch.pulse2_period, want.per2);
          if (rsp_ch.pulse1_duty !== want.duty1)
            report_mismatch("pulse1_duty", rsp_ch.pulse1_duty, want.duty1);
          if (rsp_ch.pulse2_duty !== want.duty2)
            report_mismatch("pulse2_duty", rsp_ch.pulse2_duty, want.duty2);
        end
      end
      rsp_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[pulse_channel_frame_sequencer_core] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    apu_clear();
    clk = 1'b0;
    rst = 1'b1;
    errors = 0;
    idle_cycles = 0;
    hold_left = 0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    req_ch.valid = 1'b0;
    req_ch.cmd = pcfs_pkg::CMD_WRITE;
    req_ch.reg_offset = 5'd0;
    req_ch.data = 8'd0;
    rsp_ch.ready = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    push_op(pcfs_pkg::CMD_WRITE, pcfs_pkg::OFF_ENABLE, 8'h03);
    push_op(pcfs_pkg::CMD_WRITE, chan_reg(0, pcfs_pkg::SEL_CONTROL), 8'hBF);
    push_op(pcfs_pkg::CMD_WRITE, chan_reg(0, pcfs_pkg::SEL_SWEEP), 8'h89);
    push_op(pcfs_pkg::CMD_WRITE, chan_reg(0, pcfs_pkg::SEL_LOW), 8'hFF);
    push_op(pcfs_pkg::CMD_WRITE, chan_reg(0, pcfs_pkg::SEL_HIGH), 8'hFF);
    push_op(pcfs_pkg::CMD_WRITE, chan_reg(1, pcfs_pkg::SEL_CONTROL), 8'h40);
    push_op(pcfs_pkg::CMD_WRITE, chan_reg(1, pcfs_pkg::SEL_SWEEP), 8'h89);
    push_op(pcfs_pkg::CMD_WRITE, chan_reg(1, pcfs_pkg::SEL_LOW), 8'h80);
    push_op(pcfs_pkg::CMD_WRITE, chan_reg(1, pcfs_pkg::SEL_HIGH), 8'h08);
    repeat (4) push_op(pcfs_pkg::CMD_TICK, 5'd0, 8'd0);
    push_op(pcfs_pkg::CMD_READ, 5'h1F, 8'hFF);
    push_op(pcfs_pkg::CMD_READ, 5'd0, 8'd0);
    push_op(CMD_UNKNOWN, 5'h1F, 8'hFF);
    push_op(pcfs_pkg::CMD_WRITE, OFF_UNUSED_TOP, 8'hFF);
    push_op(pcfs_pkg::CMD_WRITE, OFF_UNUSED_MID, 8'hAA);
    push_op(pcfs_pkg::CMD_WRITE, pcfs_pkg::OFF_FRAME, 8'h80);
    repeat (5) push_op(pcfs_pkg::CMD_TICK, 5'h1F, 8'hFF);
    push_op(pcfs_pkg::CMD_WRITE, pcfs_pkg::OFF_FRAME, 8'h40);
    repeat (4) push_op(pcfs_pkg::CMD_TICK, 5'd0, 8'd0);
    push_op(pcfs_pkg::CMD_WRITE, chan_reg(1, pcfs_pkg::SEL_CONTROL), 8'hC0);
    push_op(pcfs_pkg::CMD_WRITE, pcfs_pkg::OFF_ENABLE, 8'h00);
    push_op(pcfs_pkg::CMD_READ, 5'd0, 8'd0);
    push_op(pcfs_pkg::CMD_WRITE, pcfs_pkg::OFF_FRAME, 8'h00);

    push_random_phase(25);
    hold_left <= HOLD_CYCLES;
    push_random_phase(25);
    wait_sent();

    tx_idle_pct <= 58;
    rx_stall_pct <= 0;
    push_random_phase(50);
    wait_sent();

    tx_idle_pct <= 0;
    rx_stall_pct <= 58;
    push_random_phase(50);
    wait_sent();

    tx_idle_pct <= 16;
    rx_stall_pct <= 16;
    push_random_phase(50);
    wait_sent();

    while (req_ch.valid || status_expected.size() != 0) begin
      @(negedge clk);
    end
    repeat (8) @(negedge clk);
    if (status_expected.size() != 0) begin
      report_mismatch("beats still awaited", 0, status_expected.size());
    end
    if (errors == 0) begin
      $display("[pulse_channel_frame_sequencer_core] OK");
    end else begin
      $display("[pulse_channel_frame_sequencer_core] ERROR");
    end
    $finish;
  end

endmodule
